@@ rtl/usb_keys_to_keyboard_matrix_unit_assert.svh @@
// assertion macros for the key matrix unit
`ifndef USB_KEYS_TO_KEYBOARD_MATRIX_UNIT_ASSERT_SVH
`define USB_KEYS_TO_KEYBOARD_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication, held off while reset is high
`define UKKM_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ukkm assertion failed");

// next-cycle implication, held off while reset is high
`define UKKM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ukkm assertion failed");

`endif

@@ rtl/ukkm_pkg.sv @@
// shared types, constants and key table of the key matrix unit
package ukkm_pkg;

   localparam int NUM_ROWS        = 8;
   localparam int NUM_COLS        = 5;
   localparam int MAX_REPORT_KEYS = 6;
   localparam int CODE_W          = 8;
   localparam int DATA_W          = 8;
   localparam int ADDR_W          = 16;

   typedef enum logic {
      OP_KEY_REPORT = 1'b0,
      OP_PORT_READ  = 1'b1
   } op_type;

   typedef logic [CODE_W-1:0]   code_type;
   typedef logic [NUM_COLS-1:0] row_type;
   typedef row_type [NUM_ROWS-1:0] rows_type;

   localparam code_type HID_NONE   = 8'h00;
   localparam code_type HID_ENTER  = 8'h28;
   localparam code_type HID_BSPACE = 8'h2A;
   localparam code_type HID_SPACE  = 8'h2C;
   localparam code_type HID_EQUAL  = 8'h2E;

   localparam logic [DATA_W-1:0] MOD_CTRL_MASK  = 8'h11;
   localparam logic [DATA_W-1:0] MOD_SHIFT_MASK = 8'h22;

   localparam logic [DATA_W-1:0] JOY_PORT_LOW = 8'h1F;
   localparam logic [DATA_W-1:0] JOY_IDLE     = 8'h00;
   localparam logic [DATA_W-1:0] BUS_FLOAT    = 8'hFF;

   // matrix positions used for the extra keys
   localparam int CAPS_ROW  = 0;
   localparam int CAPS_COL  = 0;
   localparam int ZERO_ROW  = 4;
   localparam int ZERO_COL  = 0;
   localparam int SYM_ROW   = 7;
   localparam int SYM_COL   = 1;
   localparam int EQ_ROW    = 6;
   localparam int EQ_COL    = 1;
   localparam int PLUS_COL  = 2;

   // usage code at each matrix position, HID_NONE marks an empty slot
   localparam code_type KEY_MAP [NUM_ROWS][NUM_COLS] = '{
      '{HID_NONE,  8'h1D, 8'h1B, 8'h06, 8'h19},
      '{8'h04,     8'h16, 8'h07, 8'h09, 8'h0A},
      '{8'h14,     8'h1A, 8'h08, 8'h15, 8'h17},
      '{8'h1E,     8'h1F, 8'h20, 8'h21, 8'h22},
      '{8'h27,     8'h26, 8'h25, 8'h24, 8'h23},
      '{8'h13,     8'h12, 8'h0C, 8'h18, 8'h1C},
      '{HID_ENTER, 8'h0F, 8'h0E, 8'h0D, 8'h0B},
      '{HID_SPACE, HID_NONE, 8'h10, 8'h11, 8'h05}
   };

endpackage

@@ rtl/ukkm_report_decode.sv @@
// turns one keyboard report into the eight active-low matrix rows
module ukkm_report_decode #(
   parameter int NUM_KEYS = 6
) (
   input  logic [ukkm_pkg::DATA_W-1:0]             modifiers,
   input  ukkm_pkg::code_type [NUM_KEYS-1:0]       key_codes,
   output ukkm_pkg::rows_type                      rows
);
   import ukkm_pkg::*;

   logic shift;
   logic ctrl;
   logic bspace;

   assign shift = |(modifiers & MOD_SHIFT_MASK);
   assign ctrl  = |(modifiers & MOD_CTRL_MASK);

   always_comb begin
      rows   = '1;
      bspace = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (key_codes[k] == HID_BSPACE) begin
            bspace = 1'b1;
         end
         if (key_codes[k] == HID_EQUAL) begin
            if (shift) begin
               rows[EQ_ROW][PLUS_COL] = 1'b0;
            end else begin
               rows[EQ_ROW][EQ_COL] = 1'b0;
            end
            rows[SYM_ROW][SYM_COL] = 1'b0;
         end
         for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
               if (KEY_MAP[r][c] != HID_NONE && KEY_MAP[r][c] == key_codes[k]) begin
                  rows[r][c] = 1'b0;
               end
            end
         end
      end
      if (bspace || shift) begin
         rows[CAPS_ROW][CAPS_COL] = 1'b0;
      end
      if (bspace) begin
         rows[ZERO_ROW][ZERO_COL] = 1'b0;
      end
      if (ctrl) begin
         rows[SYM_ROW][SYM_COL] = 1'b0;
      end
   end

endmodule

@@ rtl/ukkm_port_read.sv @@
// answers one io read from the held matrix rows, or with the idle joystick value
module ukkm_port_read (
   input  logic [ukkm_pkg::ADDR_W-1:0] port_address,
   input  ukkm_pkg::rows_type          rows,
   output logic [ukkm_pkg::DATA_W-1:0] read_data,
   output logic                        port_claimed
);
   import ukkm_pkg::*;

   logic [NUM_COLS-1:0] row_and;

   // a row takes part when its address line is low
   always_comb begin
      row_and = '1;
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (!port_address[DATA_W + r]) begin
            row_and = row_and & rows[r];
         end
      end
   end

   always_comb begin
      if (!port_address[0]) begin
         read_data    = {{(DATA_W - NUM_COLS){1'b1}}, row_and};
         port_claimed = 1'b1;
      end else if (port_address[DATA_W-1:0] == JOY_PORT_LOW) begin
         read_data    = JOY_IDLE;
         port_claimed = 1'b1;
      end else begin
         read_data    = BUS_FLOAT;
         port_claimed = 1'b0;
      end
   end

endmodule

@@ rtl/usb_keys_to_keyboard_matrix_unit.sv @@
// keyboard report to key matrix unit: a read passes the input register, then the result register
// one transfer per cycle sustained; a report leaves the input register at once,
// a read waits there only while the result register is full and stalled
// reports replace all eight rows at the edge they leave the input register
// synchronous reset empties both registers and sets every row to no key pressed
`include "usb_keys_to_keyboard_matrix_unit_assert.svh"

module usb_keys_to_keyboard_matrix_unit #(
   parameter int NUM_REPORT_KEYS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [ukkm_pkg::DATA_W-1:0]   req_modifiers,
   input  ukkm_pkg::code_type            req_key_code_0,
   input  ukkm_pkg::code_type            req_key_code_1,
   input  ukkm_pkg::code_type            req_key_code_2,
   input  ukkm_pkg::code_type            req_key_code_3,
   input  ukkm_pkg::code_type            req_key_code_4,
   input  ukkm_pkg::code_type            req_key_code_5,
   input  logic [ukkm_pkg::ADDR_W-1:0]   req_port_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ukkm_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                          rsp_port_claimed
);
   import ukkm_pkg::*;

   code_type [MAX_REPORT_KEYS-1:0] req_codes;

   logic                           s1_valid_ff, s1_valid_in;
   op_type                         s1_op_ff;
   logic [DATA_W-1:0]              s1_modifiers_ff;
   code_type [NUM_REPORT_KEYS-1:0] s1_codes_ff;
   logic [ADDR_W-1:0]              s1_addr_ff;

   rows_type                       key_rows_ff;
   rows_type                       report_rows;

   logic                           out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]              out_data_ff;
   logic                           out_claimed_ff;
   logic [DATA_W-1:0]              read_data;
   logic                           port_claimed;

   logic                           out_free;
   logic                           s1_advance;
   logic                           load_in;

   logic                           read_blocked;
   logic                           report_moving;

   assign req_codes = {req_key_code_5, req_key_code_4, req_key_code_3,
                       req_key_code_2, req_key_code_1, req_key_code_0};

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (s1_op_ff == OP_KEY_REPORT || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign load_in    = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign out_valid_in = (s1_advance && s1_op_ff == OP_PORT_READ) ? 1'b1
                       : (rsp_stall ? out_valid_ff : 1'b0);

   ukkm_report_decode #(
      .NUM_KEYS (NUM_REPORT_KEYS)
   ) u_decode (
      .modifiers (s1_modifiers_ff),
      .key_codes (s1_codes_ff),
      .rows      (report_rows)
   );

   ukkm_port_read u_read (
      .port_address (s1_addr_ff),
      .rows         (key_rows_ff),
      .read_data    (read_data),
      .port_claimed (port_claimed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         key_rows_ff  <= '1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_advance && s1_op_ff == OP_KEY_REPORT) begin
            key_rows_ff <= report_rows;
         end
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (load_in) begin
         s1_op_ff        <= op_type'(req_op);
         s1_modifiers_ff <= req_modifiers;
         s1_addr_ff      <= req_port_address;
         for (int k = 0; k < NUM_REPORT_KEYS; k++) begin
            s1_codes_ff[k] <= req_codes[k];
         end
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (s1_advance && s1_op_ff == OP_PORT_READ) begin
         out_data_ff    <= read_data;
         out_claimed_ff <= port_claimed;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_data_ff;
   assign rsp_port_claimed = out_claimed_ff;

   assign read_blocked  = s1_valid_ff && s1_op_ff == OP_PORT_READ && out_valid_ff && rsp_stall;
   assign report_moving = s1_valid_ff && s1_op_ff == OP_KEY_REPORT
                       && !(out_valid_ff && rsp_stall);

   `UKKM_ASSERT_SAME(a_stall_only_on_blocked_read, clock, reset, req_stall, read_blocked)
   `UKKM_ASSERT_NEXT(a_report_gives_no_result, clock, reset, report_moving, !out_valid_ff)
   `UKKM_ASSERT_SAME(a_unclaimed_floats, clock, reset, out_valid_ff && !out_claimed_ff, out_data_ff == BUS_FLOAT)

endmodule
